/* src/stkl_pkg.sv */
// Shared types, constants and helpers for the sorted triple-key list.
package stkl_pkg;

    localparam int DEPTH = 64;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = CNT_W + 6;
    localparam int THR_W = 58;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_CHECK  = 3'd1;
    localparam logic [2:0] CMD_PRUNE  = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_DELETE = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic [15:0]        tag;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_NEW,
        CELL_LEFT,
        CELL_RIGHT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     mark_load;
        logic     mark_en;
    } cell_ctrl_t;

    typedef struct packed {
        logic ins;
        logic match;
        logic above;
    } cell_flags_t;

    // True when |a - b| < tol
    function automatic logic near_eq(input logic signed [31:0] a,
                                     input logic signed [31:0] b,
                                     input logic [15:0] tol);
        logic signed [32:0] d;
        logic [32:0]        mag;
        d   = 33'(a) - 33'(b);
        mag = d[32] ? 33'(-d) : 33'(d);
        return mag < {17'd0, tol};
    endfunction

endpackage

/* src/stkl_cell.sv */
// One list cell: holds an entry and its prune mark, compares against the item.
module stkl_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stkl_pkg::cell_ctrl_t                 ctrl,
    input  stkl_pkg::entry_t                     left_entry,
    input  stkl_pkg::entry_t                     right_entry,
    input  logic                                 right_mark,
    input  stkl_pkg::entry_t                     new_entry,
    input  logic [15:0]                          eps,
    input  logic signed [stkl_pkg::THR_W-1:0]    thr,
    output stkl_pkg::entry_t                     entry,
    output logic                                 mark,
    output stkl_pkg::cell_flags_t                flags
);
    import stkl_pkg::*;

    entry_t                  entry_reg, entry_next;
    logic                    mark_reg, mark_next;
    cell_flags_t             flags_reg, flags_next;
    logic                    n1, n2;
    logic signed [THR_W-1:0] scaled;
    logic                    gt_thr;

    // Compare stored keys with the pending item
    always_comb
    begin
        n1 = near_eq(entry_reg.k1, new_entry.k1, eps);
        n2 = near_eq(entry_reg.k2, new_entry.k2, eps);
        flags_next.ins   = (entry_reg.k1 > new_entry.k1)
                         || (n1 && (entry_reg.k2 > new_entry.k2))
                         || (n1 && n2 && (entry_reg.k3 >= new_entry.k3));
        flags_next.match = n1;
        flags_next.above = entry_reg.k1 > new_entry.k1;
        scaled = signed'({{(THR_W - 48){entry_reg.k1[31]}}, entry_reg.k1, 16'd0});
        gt_thr = scaled > thr;
    end

    // Select the next entry and mark
    always_comb
    begin
        case (ctrl.op)
            CELL_NEW:   entry_next = new_entry;
            CELL_LEFT:  entry_next = left_entry;
            CELL_RIGHT: entry_next = right_entry;
            default:    entry_next = entry_reg;
        endcase
        if (ctrl.mark_load)
            mark_next = ctrl.mark_en & gt_thr;
        else if (ctrl.op == CELL_RIGHT)
            mark_next = right_mark;
        else
            mark_next = mark_reg;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            mark_reg  <= mark_next;
            flags_reg <= flags_next;
        end
    end

    assign entry = entry_reg;
    assign mark  = mark_reg;
    assign flags = flags_reg;

endmodule

/* src/sorted_triple_key_list.sv */
// Top level of the sorted triple-key list: control sequencer over a chain of cells.
// Insert, check, read, delete, no-op and prune of under two entries pass through evaluate and apply.
// Prune of two or more entries then marks and compacts, removing up to DEPTH-1 entries,
// with the cell chain closing one gap per cycle.
// Throughput: one item at a time; input stalls while an item is in progress or a stalled result holds.
// Reset empties the list (count zero) and sets eps to 1; entry storage is not cleared.
module sorted_triple_key_list (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               eps_we,
    input  logic [15:0]        eps_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic signed [31:0] key_one,
    input  logic signed [31:0] key_two,
    input  logic signed [31:0] key_three,
    input  logic [15:0]        entry_tag,
    input  logic [5:0]         position,
    input  logic [23:0]        ratio,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [5:0]         found_position,
    output logic signed [31:0] out_key_one,
    output logic signed [31:0] out_key_two,
    output logic signed [31:0] out_key_three,
    output logic [15:0]        out_tag,
    output logic [6:0]         entry_count
);
    import stkl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_MARK,
        S_COMPACT
    } state_t;

    state_t                  state_reg, state_next;
    logic [2:0]              cmd_reg;
    entry_t                  new_entry_reg;
    logic [5:0]              pos_reg;
    logic [23:0]             ratio_reg;
    logic signed [THR_W-1:0] thr_reg, thr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [15:0]             eps_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              status_reg, status_next;
    logic [5:0]              found_reg, found_next;
    entry_t                  out_entry_reg, out_entry_next;
    logic [6:0]              out_count_reg, out_count_next;

    entry_t      cell_entry [DEPTH];
    logic        cell_mark  [DEPTH];
    cell_flags_t cell_flags [DEPTH];
    cell_ctrl_t  cell_ctrl  [DEPTH];

    logic                    accept;
    logic [DEPTH-1:0]        valid_vec, ins_hit, ins_pre, ins_before;
    logic [DEPTH-1:0]        chk_stop, chk_first, chk_match, mark_vec, mark_pre, del_sel;
    logic [IDX_W-1:0]        chk_idx;
    logic                    chk_any;
    logic [IDX_W-1:0]        pos_idx;
    logic                    pos_bad;
    logic signed [25:0]      ratio_mult;
    logic signed [THR_W-1:0] prod;

    // Build the chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        stkl_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl[i]),
            .left_entry  (cell_entry[(i == 0) ? 0 : i - 1]),
            .right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
            .right_mark  ((i == DEPTH - 1) ? 1'b0 : cell_mark[(i == DEPTH - 1) ? i : i + 1]),
            .new_entry   (new_entry_reg),
            .eps         (eps_reg),
            .thr         (thr_reg),
            .entry       (cell_entry[i]),
            .mark        (cell_mark[i]),
            .flags       (cell_flags[i])
        );
    end

    assign accept   = in_valid && !in_stall;
    assign in_stall = !((state_reg == S_IDLE) && (!out_valid_reg || !out_stall));

    // Head threshold for prune
    assign ratio_mult = signed'({1'b0, 25'(32'd65536 + 32'(ratio_reg))});
    assign prod       = ratio_mult * cell_entry[0].k1;

    // Per-cell position decode
    always_comb
    begin
        chk_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = CNT_W'(i) < count_reg;
            ins_hit[i]   = !valid_vec[i] || cell_flags[i].ins;
            chk_stop[i]  = valid_vec[i] && (cell_flags[i].match || cell_flags[i].above);
            chk_match[i] = cell_flags[i].match;
            mark_vec[i]  = cell_mark[i];
            del_sel[i]   = CMP_W'(i) >= CMP_W'(pos_reg);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            ins_pre[i]    = |(ins_hit & ~({DEPTH{1'b1}} << (i + 1)));
            ins_before[i] = |(ins_hit & ~({DEPTH{1'b1}} << i));
            chk_first[i]  = chk_stop[i] && !(|(chk_stop & ~({DEPTH{1'b1}} << i)));
            mark_pre[i]   = |(mark_vec & ~({DEPTH{1'b1}} << (i + 1)));
            if (chk_first[i] && cell_flags[i].match)
                chk_idx = chk_idx | IDX_W'(i);
        end
        chk_any = |(chk_first & chk_match);
        pos_idx = IDX_W'(pos_reg);
        pos_bad = CMP_W'(pos_reg) >= CMP_W'(count_reg);
    end

    // Sequencer: cell control, count and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        thr_next       = thr_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        found_next     = found_reg;
        out_entry_next = out_entry_reg;
        out_count_next = out_count_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_ctrl[i].op        = CELL_HOLD;
            cell_ctrl[i].mark_load = 1'b0;
            cell_ctrl[i].mark_en   = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                thr_next   = prod;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                status_next    = ST_OK;
                found_next     = '0;
                out_entry_next = '0;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                            status_next = ST_FULL;
                        else
                        begin
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                if (ins_pre[i] && !ins_before[i])
                                    cell_ctrl[i].op = CELL_NEW;
                                else if (ins_before[i])
                                    cell_ctrl[i].op = CELL_LEFT;
                            end
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_CHECK:
                    begin
                        if (chk_any)
                            found_next = 6'(chk_idx);
                        else
                            status_next = ST_NOT_FOUND;
                    end
                    CMD_PRUNE:
                    begin
                        if (count_reg > CNT_W'(1))
                        begin
                            out_valid_next = 1'b0;
                            state_next     = S_MARK;
                        end
                    end
                    CMD_READ:
                    begin
                        if (pos_bad)
                            status_next = ST_BAD_POS;
                        else
                        begin
                            out_entry_next     = cell_entry[pos_idx];
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (pos_bad)
                            status_next = ST_BAD_POS;
                        else
                        begin
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                if (del_sel[i])
                                    cell_ctrl[i].op = CELL_RIGHT;
                            end
                            count_next = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
                out_count_next = 7'(count_next);
            end
            S_MARK:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    cell_ctrl[i].mark_load = 1'b1;
                    cell_ctrl[i].mark_en   = valid_vec[i] && (i != 0);
                end
                state_next = S_COMPACT;
            end
            S_COMPACT:
            begin
                if (|mark_vec)
                begin
                    // Close the gap at the first marked entry
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (mark_pre[i])
                            cell_ctrl[i].op = CELL_RIGHT;
                    end
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_count_next = 7'(count_reg);
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, count, config and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            eps_reg       <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (eps_we)
                eps_reg <= eps_wdata;
        end
    end

    // Latch the item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg           <= command;
            new_entry_reg.k1  <= key_one;
            new_entry_reg.k2  <= key_two;
            new_entry_reg.k3  <= key_three;
            new_entry_reg.tag <= entry_tag;
            pos_reg           <= position;
            ratio_reg         <= ratio;
        end
        thr_reg       <= thr_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
        out_entry_reg <= out_entry_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign out_key_one    = out_entry_reg.k1;
    assign out_key_two    = out_entry_reg.k2;
    assign out_key_three  = out_entry_reg.k3;
    assign out_tag        = out_entry_reg.tag;
    assign entry_count    = out_count_reg;

    // Count never passes the list depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // No result is waiting while an item is in progress
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg != S_IDLE) |-> !out_valid_reg)
        else $error("result pending during item");

    // A result appears only from the apply or compaction step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_APPLY || $past(state_reg) == S_COMPACT))
        else $error("result raised from wrong state");

    // Each compaction shift removes exactly one entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMPACT && (|mark_vec)) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("compaction count slip");

endmodule
